FILE: sv/color_alpha_gradient_lerp_assert.svh
`ifndef COLOR_ALPHA_GRADIENT_LERP_ASSERT_SVH
`define COLOR_ALPHA_GRADIENT_LERP_ASSERT_SVH

// Check on every rising edge outside reset.
`define CAGL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset cycles included.
`define CAGL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cagl_pkg.sv
package cagl_pkg;

  localparam int MAX_KEYS   = 8;
  localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
  localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);

  localparam int VAL_W      = 16;
  localparam int RGB_W      = 3 * VAL_W;
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = $clog2(NUM_CH);
  localparam int CH_CNT_W   = $clog2(NUM_CH + 1);

  localparam logic [VAL_W-1:0]     VAL_ONE         = '1;
  localparam logic [CH_W-1:0]      CH_ALPHA        = CH_W'(NUM_CH - 1);

  localparam logic [MODE_W-1:0]    MODE_WR_COLOR   = 2'd0;
  localparam logic [MODE_W-1:0]    MODE_WR_ALPHA   = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_EVAL       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DIV,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  tag;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] f;
  } blend_req_t;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  tag;
    logic [VAL_W-1:0] value;
  } blend_res_t;

  // Saturate a programmed key count to the table depth.
  function automatic logic [KEY_CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] c);
    if (32'(c) > MAX_KEYS) begin
      return KEY_CNT_W'(MAX_KEYS);
    end
    return KEY_CNT_W'(c);
  endfunction

endpackage

FILE: sv/color_alpha_gradient_lerp.sv
// Key writes: one per cycle while idle, stored at the edge that takes them; no result.
// Evaluation: a key scan of both tables, a divider run when a table interpolates,
// then the shared blend over all four channels, and the result into the output register.
// One evaluation at a time; no new item is taken until its result is loaded.
// Reset (rst_n low, synchronous) clears the state machine, key counts and result valid;
// key tables are not cleared and hold garbage until written.
module color_alpha_gradient_lerp (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cagl_pkg::MODE_W-1:0]       in_mode,
  input  logic [cagl_pkg::SLOT_W-1:0]       in_key_slot,
  input  logic [cagl_pkg::VAL_W-1:0]        in_key_time,
  input  logic [cagl_pkg::VAL_W-1:0]        in_key_red,
  input  logic [cagl_pkg::VAL_W-1:0]        in_key_green,
  input  logic [cagl_pkg::VAL_W-1:0]        in_key_blue,
  input  logic [cagl_pkg::VAL_W-1:0]        in_key_alpha,
  input  logic [cagl_pkg::VAL_W-1:0]        in_sample_time,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cagl_pkg::VAL_W-1:0]        out_red,
  output logic [cagl_pkg::VAL_W-1:0]        out_green,
  output logic [cagl_pkg::VAL_W-1:0]        out_blue,
  output logic [cagl_pkg::VAL_W-1:0]        out_alpha,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cagl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cagl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import cagl_pkg::*;

  `include "color_alpha_gradient_lerp_assert.svh"

  localparam int C_MEM_W = VAL_W + RGB_W;
  localparam int A_MEM_W = 2 * VAL_W;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] color_count_r;
  logic [CFG_DATA_W-1:0] alpha_count_r;

  logic in_xfer;
  logic key_slot_ok;
  logic c_we;
  logic a_we;
  logic eval_xfer;

  // Outputs of the control decode.
  logic scan_issue;
  logic c_div_start;
  logic a_div_start;
  logic blend_issue;
  logic out_load;

  // ---------------------------------------------------------------------------
  // Key tables: color {time, red, green, blue}, alpha {time, alpha}.
  // Writes land only while idle and reads only during the scan, so a read
  // never races a write to the same slot.
  // ---------------------------------------------------------------------------
  logic [KEY_IDX_W-1:0] wr_addr;
  logic [KEY_IDX_W-1:0] rd_addr;
  logic [C_MEM_W-1:0]   c_rdata;
  logic [A_MEM_W-1:0]   a_rdata;

  assign in_xfer     = in_valid && !in_stall;
  assign key_slot_ok = 32'(in_key_slot) < MAX_KEYS;
  assign c_we        = in_xfer && (in_mode == MODE_WR_COLOR) && key_slot_ok;
  assign a_we        = in_xfer && (in_mode == MODE_WR_ALPHA) && key_slot_ok;
  assign eval_xfer   = in_xfer && (in_mode == MODE_EVAL);
  assign wr_addr     = KEY_IDX_W'(in_key_slot);

  cagl_ram #(
    .WIDTH (C_MEM_W),
    .DEPTH (MAX_KEYS)
  ) u_color_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (wr_addr),
    .wdata ({in_key_time, in_key_red, in_key_green, in_key_blue}),
    .raddr (rd_addr),
    .rdata (c_rdata)
  );

  cagl_ram #(
    .WIDTH (A_MEM_W),
    .DEPTH (MAX_KEYS)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata ({in_key_time, in_key_alpha}),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  // ---------------------------------------------------------------------------
  // Configuration: key counts, written whenever offered.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= '0;
      alpha_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLOR_COUNT: color_count_r <= cfg_data;
        CFG_ALPHA_COUNT: alpha_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scan: step one slot per cycle through both tables at once. Read data
  // comes back in the next cycle and is checked against the sample time.
  // Strict compares keep the lower slot on equal key times.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]     t_r;
  logic [KEY_CNT_W-1:0] c_cnt_r;
  logic [KEY_CNT_W-1:0] a_cnt_r;
  logic [KEY_CNT_W-1:0] rd_idx_r;
  logic                 chk_vld_r;
  logic [KEY_CNT_W-1:0] chk_idx_r;

  logic                 c_has_lo_r, c_has_hi_r;
  logic [VAL_W-1:0]     c_lo_time_r, c_hi_time_r;
  logic [RGB_W-1:0]     c_lo_val_r, c_hi_val_r;
  logic                 a_has_lo_r, a_has_hi_r;
  logic [VAL_W-1:0]     a_lo_time_r, a_hi_time_r;
  logic [VAL_W-1:0]     a_lo_val_r, a_hi_val_r;

  logic [VAL_W-1:0]     c_rd_time;
  logic [RGB_W-1:0]     c_rd_val;
  logic [VAL_W-1:0]     a_rd_time;
  logic [VAL_W-1:0]     a_rd_val;
  logic                 c_chk, a_chk;
  logic                 c_lo_upd, c_hi_upd, a_lo_upd, a_hi_upd;

  assign rd_addr   = rd_idx_r[KEY_IDX_W-1:0];
  assign c_rd_time = c_rdata[RGB_W +: VAL_W];
  assign c_rd_val  = c_rdata[RGB_W-1:0];
  assign a_rd_time = a_rdata[VAL_W +: VAL_W];
  assign a_rd_val  = a_rdata[VAL_W-1:0];

  assign c_chk    = chk_vld_r && (chk_idx_r < c_cnt_r);
  assign a_chk    = chk_vld_r && (chk_idx_r < a_cnt_r);
  assign c_lo_upd = c_chk && (c_rd_time <= t_r) && (!c_has_lo_r || (c_rd_time > c_lo_time_r));
  assign c_hi_upd = c_chk && (c_rd_time >= t_r) && (!c_has_hi_r || (c_rd_time < c_hi_time_r));
  assign a_lo_upd = a_chk && (a_rd_time <= t_r) && (!a_has_lo_r || (a_rd_time > a_lo_time_r));
  assign a_hi_upd = a_chk && (a_rd_time >= t_r) && (!a_has_hi_r || (a_rd_time < a_hi_time_r));

  always_ff @(posedge clk) begin
    if (eval_xfer) begin
      t_r        <= in_sample_time;
      c_cnt_r    <= clamp_count(color_count_r);
      a_cnt_r    <= clamp_count(alpha_count_r);
      rd_idx_r   <= '0;
      c_has_lo_r <= 1'b0;
      c_has_hi_r <= 1'b0;
      a_has_lo_r <= 1'b0;
      a_has_hi_r <= 1'b0;
    end else begin
      if (scan_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (c_lo_upd) begin
        c_has_lo_r  <= 1'b1;
        c_lo_time_r <= c_rd_time;
        c_lo_val_r  <= c_rd_val;
      end
      if (c_hi_upd) begin
        c_has_hi_r  <= 1'b1;
        c_hi_time_r <= c_rd_time;
        c_hi_val_r  <= c_rd_val;
      end
      if (a_lo_upd) begin
        a_has_lo_r  <= 1'b1;
        a_lo_time_r <= a_rd_time;
        a_lo_val_r  <= a_rd_val;
      end
      if (a_hi_upd) begin
        a_has_hi_r  <= 1'b1;
        a_hi_time_r <= a_rd_time;
        a_hi_val_r  <= a_rd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_idx_r;
  end

  // ---------------------------------------------------------------------------
  // Pick: choose blend endpoints per table. Empty table gives 1.0; a time
  // before all keys takes the upper key; after all keys or on equal bracket
  // times take the lower key; otherwise interpolate and start the divider.
  // ---------------------------------------------------------------------------
  logic             c_interp, a_interp;
  logic [RGB_W-1:0] c_a_sel, c_b_sel;
  logic [VAL_W-1:0] a_a_sel, a_b_sel;
  logic [RGB_W-1:0] c_a_r, c_b_r;
  logic [VAL_W-1:0] a_a_r, a_b_r;
  logic             c_interp_r, a_interp_r;

  always_comb begin
    c_interp = 1'b0;
    c_a_sel  = c_lo_val_r;
    c_b_sel  = c_lo_val_r;
    priority if (c_cnt_r == '0) begin
      c_a_sel = {3{VAL_ONE}};
      c_b_sel = {3{VAL_ONE}};
    end else if (!c_has_lo_r) begin
      c_a_sel = c_hi_val_r;
      c_b_sel = c_hi_val_r;
    end else if (!c_has_hi_r || (c_lo_time_r == c_hi_time_r)) begin
      c_a_sel = c_lo_val_r;
      c_b_sel = c_lo_val_r;
    end else begin
      c_interp = 1'b1;
      c_a_sel  = c_lo_val_r;
      c_b_sel  = c_hi_val_r;
    end
  end

  always_comb begin
    a_interp = 1'b0;
    a_a_sel  = a_lo_val_r;
    a_b_sel  = a_lo_val_r;
    priority if (a_cnt_r == '0) begin
      a_a_sel = VAL_ONE;
      a_b_sel = VAL_ONE;
    end else if (!a_has_lo_r) begin
      a_a_sel = a_hi_val_r;
      a_b_sel = a_hi_val_r;
    end else if (!a_has_hi_r || (a_lo_time_r == a_hi_time_r)) begin
      a_a_sel = a_lo_val_r;
      a_b_sel = a_lo_val_r;
    end else begin
      a_interp = 1'b1;
      a_a_sel  = a_lo_val_r;
      a_b_sel  = a_hi_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PICK) begin
      c_a_r      <= c_a_sel;
      c_b_r      <= c_b_sel;
      a_a_r      <= a_a_sel;
      a_b_r      <= a_b_sel;
      c_interp_r <= c_interp;
      a_interp_r <= a_interp;
    end
  end

  // ---------------------------------------------------------------------------
  // Fractions: one divider per table, run side by side.
  // ---------------------------------------------------------------------------
  logic             c_div_busy, a_div_busy;
  logic [VAL_W-1:0] c_quot, a_quot;
  logic [VAL_W-1:0] c_frac, a_frac;

  cagl_div u_color_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_div_start),
    .num   (t_r - c_lo_time_r),
    .den   (c_hi_time_r - c_lo_time_r),
    .busy  (c_div_busy),
    .quot  (c_quot)
  );

  cagl_div u_alpha_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (a_div_start),
    .num   (t_r - a_lo_time_r),
    .den   (a_hi_time_r - a_lo_time_r),
    .busy  (a_div_busy),
    .quot  (a_quot)
  );

  // Non-interpolating tables blend with a zero fraction, which passes a through.
  assign c_frac = c_interp_r ? c_quot : '0;
  assign a_frac = a_interp_r ? a_quot : '0;

  // ---------------------------------------------------------------------------
  // Blend: feed red, green, blue, alpha through the shared blend unit.
  // ---------------------------------------------------------------------------
  logic [CH_CNT_W-1:0] ch_r;
  logic [CH_W-1:0]     ch;
  blend_req_t          blend_req;
  blend_res_t          blend_res;
  logic [VAL_W-1:0]    res_r [NUM_CH];

  assign ch = ch_r[CH_W-1:0];

  always_comb begin
    blend_req.valid = blend_issue;
    blend_req.tag   = ch;
    blend_req.f     = (ch == CH_ALPHA) ? a_frac : c_frac;
    if (ch == CH_ALPHA) begin
      blend_req.a = a_a_r;
      blend_req.b = a_b_r;
    end else begin
      // Channel 0 is red, in the top field of the packed color.
      blend_req.a = c_a_r[RGB_W - VAL_W * (32'(ch) + 1) +: VAL_W];
      blend_req.b = c_b_r[RGB_W - VAL_W * (32'(ch) + 1) +: VAL_W];
    end
  end

  cagl_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (blend_req),
    .res   (blend_res)
  );

  always_ff @(posedge clk) begin
    if (state_r != ST_BLEND) begin
      ch_r <= '0;
    end else if (blend_issue) begin
      ch_r <= ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (blend_res.valid) begin
      res_r[blend_res.tag] <= blend_res.value;
    end
  end

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (eval_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((32'(rd_idx_r) == MAX_KEYS) && !chk_vld_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!c_div_busy && !a_div_busy) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (blend_res.valid && (blend_res.tag == CH_ALPHA)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    scan_issue  = (state_r == ST_SCAN) && (32'(rd_idx_r) < MAX_KEYS);
    c_div_start = (state_r == ST_PICK) && c_interp;
    a_div_start = (state_r == ST_PICK) && a_interp;
    blend_issue = (state_r == ST_BLEND) && (32'(ch_r) < NUM_CH);
    out_load    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold a stalled result, let the next item in meanwhile.
  // ---------------------------------------------------------------------------
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= res_r[0];
      out_green_r <= res_r[1];
      out_blue_r  <= res_r[2];
      out_alpha_r <= res_r[CH_ALPHA];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CAGL_ASSERT(a_eval_starts_scan, eval_xfer |=> (state_r == ST_SCAN), "evaluate transfer did not start the scan")
  `CAGL_ASSERT(a_out_from_done, $rose(out_valid) |-> ($past(state_r) == ST_DONE), "result raised outside the done state")
  `CAGL_ASSERT(a_div_only_in_div, (state_r != ST_DIV) |-> (!c_div_busy && !a_div_busy), "divider busy outside the divide state")
  `CAGL_ASSERT(a_blend_in_blend, blend_res.valid |-> (state_r == ST_BLEND), "blend result outside the blend state")
  `CAGL_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> ((state_r == ST_IDLE) && !out_valid), "reset left control state set")

endmodule

FILE: sv/cagl_ram.sv
module cagl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/cagl_div.sv
module cagl_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cagl_pkg::VAL_W-1:0] num,
  input  logic [cagl_pkg::VAL_W-1:0] den,
  output logic                      busy,
  output logic [cagl_pkg::VAL_W-1:0] quot
);

  import cagl_pkg::*;

  localparam int STEP_W = $clog2(VAL_W);

  // Restoring division of (num << VAL_W) by den, one quotient bit a cycle.
  // num < den, so the remainder never needs more than VAL_W + 1 bits.
  logic              busy_r,  busy_nxt;
  logic [STEP_W-1:0] step_r,  step_nxt;
  logic [VAL_W:0]    rem_r,   rem_nxt;
  logic [VAL_W-1:0]  den_r,   den_nxt;
  logic [VAL_W-1:0]  quot_r,  quot_nxt;
  logic [VAL_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_r[VAL_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = fits ? (shifted - {1'b0, den_r}) : shifted;
      quot_nxt = {quot_r[VAL_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

FILE: sv/cagl_blend.sv
module cagl_blend (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cagl_pkg::blend_req_t   req,
  output cagl_pkg::blend_res_t   res
);

  import cagl_pkg::*;

  localparam int PROD_W = 2 * (VAL_W + 1);

  // Stage 1: signed difference times fraction. Stage 2: add the floored step.
  logic signed [VAL_W:0]    diff;
  logic signed [VAL_W:0]    frac;
  logic signed [PROD_W-1:0] prod;

  logic                     s1_valid_r;
  logic [CH_W-1:0]          s1_tag_r;
  logic [VAL_W-1:0]         s1_a_r;
  logic signed [PROD_W-1:0] s1_prod_r;

  logic signed [PROD_W-VAL_W-1:0] step;
  logic [PROD_W-VAL_W-1:0]        sum;

  logic                     s2_valid_r;
  logic [CH_W-1:0]          s2_tag_r;
  logic [VAL_W-1:0]         s2_value_r;

  assign diff = $signed({1'b0, req.b}) - $signed({1'b0, req.a});
  assign frac = $signed({1'b0, req.f});
  assign prod = diff * frac;

  // Arithmetic shift keeps floor semantics for negative products.
  assign step = s1_prod_r[PROD_W-1:VAL_W];
  assign sum  = (PROD_W - VAL_W)'(s1_a_r) + step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r   <= req.tag;
    s1_a_r     <= req.a;
    s1_prod_r  <= prod;
    s2_tag_r   <= s1_tag_r;
    s2_value_r <= sum[VAL_W-1:0];
  end

  assign res.valid = s2_valid_r;
  assign res.tag   = s2_tag_r;
  assign res.value = s2_value_r;

endmodule

FILE: sim/tb_color_alpha_gradient_lerp.sv
`timescale 1ns / 1ps

module tb_color_alpha_gradient_lerp;
  import cagl_pkg::*;

  // Mode 3 has no name in the package; the block drops it without a result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int QUIET       = 64;    // settling wait that outlasts one evaluation
  localparam int STALL_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off used to back up the block
  localparam int RAND_PHASES = 12;
  localparam int PHASE_OPS   = 140;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  key_time;
    logic [VAL_W-1:0]  red;
    logic [VAL_W-1:0]  green;
    logic [VAL_W-1:0]  blue;
    logic [VAL_W-1:0]  alpha;
    logic [VAL_W-1:0]  sample_time;
  } grad_op_t;

  typedef struct {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] alpha;
  } rgba_t;

  // How one table resolves a sample time.
  typedef enum int {USE_ONE, USE_LOWER, USE_UPPER, USE_LERP} key_pick_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [SLOT_W-1:0]     in_key_slot = '0;
  logic [VAL_W-1:0]      in_key_time = '0;
  logic [VAL_W-1:0]      in_key_red = '0;
  logic [VAL_W-1:0]      in_key_green = '0;
  logic [VAL_W-1:0]      in_key_blue = '0;
  logic [VAL_W-1:0]      in_key_alpha = '0;
  logic [VAL_W-1:0]      in_sample_time = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VAL_W-1:0]      out_red;
  logic [VAL_W-1:0]      out_green;
  logic [VAL_W-1:0]      out_blue;
  logic [VAL_W-1:0]      out_alpha;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  color_alpha_gradient_lerp u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_key_slot    (in_key_slot),
    .in_key_time    (in_key_time),
    .in_key_red     (in_key_red),
    .in_key_green   (in_key_green),
    .in_key_blue    (in_key_blue),
    .in_key_alpha   (in_key_alpha),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Mirror of the key tables and counts, updated at each transfer in the order taken.
  logic [VAL_W-1:0]      color_time_q [MAX_KEYS];
  logic [VAL_W-1:0]      color_rgb_q  [MAX_KEYS][3];
  logic [VAL_W-1:0]      alpha_time_q [MAX_KEYS];
  logic [VAL_W-1:0]      alpha_val_q  [MAX_KEYS];
  logic [CFG_DATA_W-1:0] color_count_q = '0;
  logic [CFG_DATA_W-1:0] alpha_count_q = '0;

  grad_op_t gradient_ops [$];   // items waiting to be offered
  rgba_t    due_colors   [$];   // colors owed by the block, oldest first
  grad_op_t on_bus;             // item currently presented on the input port

  int send_gap_pct = 21;
  int recv_gap_pct = 65;
  int fault_count  = 0;
  int idle_cycles  = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;
  bit hold_go      = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Blend a toward b by f/65536, flooring the signed step.
  function automatic logic [VAL_W-1:0] lerp16(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [VAL_W-1:0] f);
    longint d;
    longint step;
    d    = longint'(b) - longint'(a);
    step = (d * longint'(f)) >>> 16;
    return VAL_W'(longint'(a) + step);
  endfunction

  // Find the keys around t in one table. Ties on time go to the lower slot, which the
  // strict comparisons give for free since slots are scanned upward.
  function automatic void bracket_keys(input bit alpha_tbl, input logic [VAL_W-1:0] t,
                                       output key_pick_t how, output int lo,
                                       output int hi, output logic [VAL_W-1:0] frac);
    logic [VAL_W-1:0]      tk [MAX_KEYS];
    logic [CFG_DATA_W-1:0] cnt;
    logic [VAL_W-1:0]      span;
    logic [31:0]           num;
    bit                    has_lo;
    bit                    has_hi;
    int                    n;
    int                    i;
    cnt = alpha_tbl ? alpha_count_q : color_count_q;
    n   = (cnt > MAX_KEYS) ? MAX_KEYS : int'(cnt);   // counts above the depth saturate
    for (i = 0; i < MAX_KEYS; i++) begin
      tk[i] = alpha_tbl ? alpha_time_q[i] : color_time_q[i];
    end
    has_lo = 1'b0;
    has_hi = 1'b0;
    lo     = 0;
    hi     = 0;
    frac   = '0;
    for (i = 0; i < n; i++) begin
      if (tk[i] <= t && (!has_lo || tk[i] > tk[lo])) begin
        has_lo = 1'b1;
        lo     = i;
      end
      if (tk[i] >= t && (!has_hi || tk[i] < tk[hi])) begin
        has_hi = 1'b1;
        hi     = i;
      end
    end
    if (n == 0) begin
      how = USE_ONE;
    end else if (!has_lo) begin
      how = USE_UPPER;                      // t before every key
    end else if (!has_hi || tk[lo] == tk[hi]) begin
      how = USE_LOWER;                      // t after every key, or a zero-width span
    end else begin
      how  = USE_LERP;
      span = tk[hi] - tk[lo];
      num  = {t - tk[lo], 16'h0000};
      frac = VAL_W'(num / span);
    end
  endfunction

  function automatic rgba_t gradient_at(input logic [VAL_W-1:0] t);
    rgba_t            res;
    key_pick_t        how;
    int               lo;
    int               hi;
    int               c;
    logic [VAL_W-1:0] f;
    logic [VAL_W-1:0] v [3];
    bracket_keys(1'b0, t, how, lo, hi, f);
    for (c = 0; c < 3; c++) begin
      case (how)
        USE_ONE:   v[c] = VAL_ONE;
        USE_LOWER: v[c] = color_rgb_q[lo][c];
        USE_UPPER: v[c] = color_rgb_q[hi][c];
        default:   v[c] = lerp16(color_rgb_q[lo][c], color_rgb_q[hi][c], f);
      endcase
    end
    res.red   = v[0];
    res.green = v[1];
    res.blue  = v[2];
    bracket_keys(1'b1, t, how, lo, hi, f);
    case (how)
      USE_ONE:   res.alpha = VAL_ONE;
      USE_LOWER: res.alpha = alpha_val_q[lo];
      USE_UPPER: res.alpha = alpha_val_q[hi];
      default:   res.alpha = lerp16(alpha_val_q[lo], alpha_val_q[hi], f);
    endcase
    return res;
  endfunction

  // Apply one accepted item to the mirror; evaluations queue the color they owe.
  function automatic void commit_op(input grad_op_t op);
    case (op.mode)
      MODE_WR_COLOR: begin
        color_time_q[op.slot]   = op.key_time;
        color_rgb_q[op.slot][0] = op.red;
        color_rgb_q[op.slot][1] = op.green;
        color_rgb_q[op.slot][2] = op.blue;
      end
      MODE_WR_ALPHA: begin
        alpha_time_q[op.slot] = op.key_time;
        alpha_val_q[op.slot]  = op.alpha;
      end
      MODE_EVAL: begin
        due_colors.push_back(gradient_at(op.sample_time));
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  // Every field random; the fields a mode does not use stay as noise.
  function automatic grad_op_t noise_op();
    grad_op_t op;
    op.mode        = MODE_W'($urandom_range(3));
    op.slot        = SLOT_W'($urandom_range(7));
    op.key_time    = VAL_W'($urandom);
    op.red         = VAL_W'($urandom);
    op.green       = VAL_W'($urandom);
    op.blue        = VAL_W'($urandom);
    op.alpha       = VAL_W'($urandom);
    op.sample_time = VAL_W'($urandom);
    return op;
  endfunction

  function automatic grad_op_t color_key(input int slot, input logic [VAL_W-1:0] t,
                                         input logic [VAL_W-1:0] r,
                                         input logic [VAL_W-1:0] g,
                                         input logic [VAL_W-1:0] b);
    grad_op_t op;
    op          = noise_op();
    op.mode     = MODE_WR_COLOR;
    op.slot     = SLOT_W'(slot);
    op.key_time = t;
    op.red      = r;
    op.green    = g;
    op.blue     = b;
    return op;
  endfunction

  function automatic grad_op_t alpha_key(input int slot, input logic [VAL_W-1:0] t,
                                         input logic [VAL_W-1:0] a);
    grad_op_t op;
    op          = noise_op();
    op.mode     = MODE_WR_ALPHA;
    op.slot     = SLOT_W'(slot);
    op.key_time = t;
    op.alpha    = a;
    return op;
  endfunction

  function automatic grad_op_t eval_at(input logic [VAL_W-1:0] t);
    grad_op_t op;
    op             = noise_op();
    op.mode        = MODE_EVAL;
    op.sample_time = t;
    return op;
  endfunction

  // Lean on a few shared times so duplicate keys and exact hits come up often.
  function automatic logic [VAL_W-1:0] pick_time();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return VAL_W'($urandom_range(3) * 16'h4000 + 16'h1000);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic grad_op_t rand_op();
    grad_op_t op;
    int       k;
    op = noise_op();
    k  = $urandom_range(99);
    if (k < 22) begin
      op = color_key($urandom_range(7), pick_time(), pick_value(), pick_value(),
                     pick_value());
    end else if (k < 40) begin
      op = alpha_key($urandom_range(7), pick_time(), pick_value());
    end else if (k < 45) begin
      op.mode = MODE_UNUSED;
    end else begin
      op = eval_at(pick_time());
      // Land just beside a key now and then.
      case ($urandom_range(3))
        0:       op.sample_time = op.sample_time + 1'b1;
        1:       op.sample_time = op.sample_time - 1'b1;
        default: ;
      endcase
    end
    return op;
  endfunction

  // Rotate through empty, full and saturated counts, with a random one between.
  function automatic logic [CFG_DATA_W-1:0] count_for(input int k);
    case (k % 4)
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_KEYS);
      2:       return '1;
      default: return CFG_DATA_W'($urandom_range(15));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Control-side tasks
  // ---------------------------------------------------------------------------

  // Write one count register; called only while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COLOR_COUNT) begin
      color_count_q = val;
    end else if (idx == CFG_ALPHA_COUNT) begin
      alpha_count_q = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued item to transfer and every owed color to arrive, then let
  // the block finish any dropped item before touching the registers again.
  task automatic settle();
    do @(posedge clk);
    while (gradient_ops.size() != 0 || in_valid || due_colors.size() != 0);
    repeat (QUIET) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items; hold the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        commit_op(on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (gradient_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = gradient_ops.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= on_bus.mode;
          in_key_slot    <= on_bus.slot;
          in_key_time    <= on_bus.key_time;
          in_key_red     <= on_bus.red;
          in_key_green   <= on_bus.green;
          in_key_blue    <= on_bus.blue;
          in_key_alpha   <= on_bus.alpha;
          in_sample_time <= on_bus.sample_time;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once armed, keep the receiver stalled for HOLD_CYCLES.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest owed color.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    rgba_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_colors.size() == 0) begin
          $display("%0t ns: result expected none got %h %h %h %h", $time,
                   out_red, out_green, out_blue, out_alpha);
          fault_count++;
        end else begin
          want = due_colors.pop_front();
          check_field("out_red",   want.red,   out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue",  want.blue,  out_blue);
          check_field("out_alpha", want.alpha, out_alpha);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no channel moves for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Counts come out of reset at zero: both tables empty give full white.
    gradient_ops.push_back(eval_at(16'hFFFF));
    gradient_ops.push_back(noise_op());
    gradient_ops[$].mode = MODE_UNUSED;

    // Fill every slot before any count can reach it. Keys go in out of order, with
    // repeated times, and with extreme times and values.
    gradient_ops.push_back(color_key(0, 16'h4000, 16'hFFFF, 16'h0000, 16'h8000));
    gradient_ops.push_back(color_key(1, 16'h1000, 16'h0000, 16'hFFFF, 16'h1234));
    gradient_ops.push_back(color_key(2, 16'hC000, 16'h8000, 16'h8001, 16'hFFFF));
    gradient_ops.push_back(color_key(3, 16'h1000, 16'hFFFF, 16'hFFFF, 16'h0000));
    gradient_ops.push_back(color_key(4, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001));
    gradient_ops.push_back(color_key(5, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    gradient_ops.push_back(color_key(6, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    gradient_ops.push_back(color_key(7, 16'h8000, 16'h0F0F, 16'hF0F0, 16'h7FFF));
    gradient_ops.push_back(alpha_key(0, 16'h2000, 16'hFFFF));
    gradient_ops.push_back(alpha_key(1, 16'hE000, 16'h0000));
    gradient_ops.push_back(alpha_key(2, 16'h2000, 16'h8000));
    gradient_ops.push_back(alpha_key(3, 16'h0000, 16'h1111));
    gradient_ops.push_back(alpha_key(4, 16'hFFFF, 16'hFFFF));
    gradient_ops.push_back(alpha_key(5, 16'h7000, 16'h0001));
    gradient_ops.push_back(alpha_key(6, 16'hE000, 16'hFFFE));
    gradient_ops.push_back(alpha_key(7, 16'h9000, 16'h4000));
    settle();

    // Four color keys, three alpha keys: before all, exact hit on a repeated time,
    // rising blend, falling blend, after all.
    write_reg(CFG_COLOR_COUNT, 4'd4);
    write_reg(CFG_ALPHA_COUNT, 4'd3);
    gradient_ops.push_back(eval_at(16'h0000));
    gradient_ops.push_back(eval_at(16'h1000));
    gradient_ops.push_back(eval_at(16'h2000));
    gradient_ops.push_back(eval_at(16'h9000));
    gradient_ops.push_back(eval_at(16'hFFFF));
    settle();

    // Saturated color count against a full alpha table.
    write_reg(CFG_COLOR_COUNT, '1);
    write_reg(CFG_ALPHA_COUNT, CFG_DATA_W'(MAX_KEYS));
    gradient_ops.push_back(eval_at(16'h0000));
    gradient_ops.push_back(eval_at(16'h7FFF));
    gradient_ops.push_back(eval_at(16'hFFFF));
    settle();

    // Random phases: sender-light idling, then receiver-light, then none at all.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < RAND_PHASES / 3) begin
        send_gap_pct = 21;
        recv_gap_pct = 65;
      end else if (ph < 2 * RAND_PHASES / 3) begin
        send_gap_pct = 65;
        recv_gap_pct = 21;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      write_reg(CFG_COLOR_COUNT, count_for(ph));
      write_reg(CFG_ALPHA_COUNT, count_for(ph + 1));
      repeat (PHASE_OPS) gradient_ops.push_back(rand_op());
      // Back the block up once while the sender streams without gaps.
      if (ph == 2 * RAND_PHASES / 3 + 1) begin
        hold_go <= 1'b1;
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
